// File: hw/rtl/sobel_pkg.sv
package sobel_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int COL_W       = 10;
    localparam int PIX_W       = 24;
    localparam int RING_DEPTH  = 4 * MAX_WIDTH;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0] back;
        logic [RING_AW-1:0] head;
        logic [WIDTH_W-1:0] width;
        logic               r_first;
        logic               r_last;
        logic               c_first;
        logic               c_last;
    } cmd_t;

endpackage

// File: hw/rtl/sobel_if.sv
interface pix_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output op, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink (input valid, input op, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

interface edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_end;

    modport source (output valid, output red_edge, output green_edge,
                    output blue_edge, output frame_end, input ready);
    modport sink (input valid, input red_edge, input green_edge,
                  input blue_edge, input frame_end, output ready);
endinterface

// File: hw/rtl/sobel_ram.sv
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sobel_front.sv
module sobel_front
    import sobel_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    pix_if.sink                 pixels,
    input  logic [WIDTH_W-1:0]  line_width,
    input  logic [HEIGHT_W-1:0] frame_height,
    output logic                ram_we,
    output logic [RING_AW-1:0]  ram_waddr,
    output logic [PIX_W-1:0]    ram_wdata,
    output logic                cmd_push,
    output cmd_t                cmd_data,
    input  logic                cmd_full
);

    logic [RING_AW-1:0]  head_reg, head_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [WIDTH_W-1:0]  pend_reg, pend_next;
    logic [WIDTH_W-1:0]  w_eff, w_plus;
    logic [HEIGHT_W-1:0] h_eff;
    logic                accept, is_pix, emit;
    logic                c_last, r_last;
    logic [WIDTH_W:0]    col_inc;
    logic [HEIGHT_W:0]   row_inc;

    always_comb
    begin
        if (line_width == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (line_width > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = line_width;
        end
        h_eff = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
    end

    assign w_plus  = w_eff + WIDTH_W'(1);
    assign pixels.ready = !cmd_full;
    assign accept  = pixels.valid && pixels.ready;
    assign is_pix  = (pixels.op == OP_PIXEL);
    assign col_inc = {2'b00, col_reg} + (WIDTH_W+1)'(1);
    assign row_inc = {1'b0, row_reg} + (HEIGHT_W+1)'(1);
    assign c_last  = col_inc >= {1'b0, w_eff};
    assign r_last  = row_inc >= {1'b0, h_eff};

    always_comb
    begin
        head_next = head_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        emit      = 1'b0;
        ram_we    = 1'b0;
        if (accept)
        begin
            if (is_pix)
            begin
                head_next = head_reg + RING_AW'(1);
                ram_we    = 1'b1;
                if (pend_reg >= w_plus)
                begin
                    pend_next = w_plus;
                    emit      = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg + WIDTH_W'(1);
                end
            end
            else if (pend_reg != '0)
            begin
                pend_next = pend_reg - WIDTH_W'(1);
                emit      = 1'b1;
            end
        end
        if (emit)
        begin
            if (c_last)
            begin
                col_next = '0;
                row_next = r_last ? '0 : row_inc[HEIGHT_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    assign ram_waddr = head_next;
    assign ram_wdata = {pixels.red_in, pixels.green_in, pixels.blue_in};
    assign cmd_push  = emit;

    always_comb
    begin
        cmd_data.back    = is_pix ? w_plus : pend_reg - WIDTH_W'(1);
        cmd_data.head    = head_next;
        cmd_data.width   = w_eff;
        cmd_data.r_first = (row_reg == '0);
        cmd_data.r_last  = r_last;
        cmd_data.c_first = (col_reg == '0);
        cmd_data.c_last  = c_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// File: hw/rtl/sobel_cmdq.sv
module sobel_cmdq
    import sobel_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    output logic avail,
    output cmd_t pop_data,
    input  logic pop
);

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, wr_next;
    logic [QUEUE_AW-1:0] rd_reg, rd_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full     = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign avail    = (cnt_reg != '0);
    assign pop_data = slot_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + QUEUE_AW'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QUEUE_AW'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (QUEUE_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/sobel_back.sv
module sobel_back
    import sobel_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  cmd_t               cmd_in,
    output logic               cmd_pop,
    output logic [RING_AW-1:0] ram_raddr,
    input  logic [PIX_W-1:0]   ram_rdata,
    edge_if.source             edges
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TAP  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [3:0] LAST_TAP = 4'd9;

    logic [2:0]         state_reg, state_next;
    cmd_t               cmd_reg;
    logic [3:0]         tap_reg;
    logic               tv_reg;
    logic signed [2:0]  wx_reg, wy_reg;
    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic [19:0]        sqx_reg [3];
    logic [19:0]        sqy_reg [3];
    logic [20:0]        sum_reg [3];
    logic [7:0]         m_reg [3];
    logic [2:0]         bit_reg;

    logic signed [1:0]  dr, dc;
    logic signed [2:0]  wx, wy;
    logic signed [12:0] kk, offs;
    logic               skip;
    logic [7:0]         probe [3];
    logic [15:0]        prod [3];

    function automatic logic signed [10:0] term(input logic signed [2:0] wt,
                                                input logic [7:0] v);
        logic signed [10:0] sv;
        sv = $signed({3'b000, v});
        case (wt)
            3'sd1:   term = sv;
            3'sd2:   term = sv <<< 1;
            -3'sd1:  term = -sv;
            -3'sd2:  term = -(sv <<< 1);
            default: term = '0;
        endcase
    endfunction

    always_comb
    begin
        case (tap_reg)
            4'd0:    begin dr = -2'sd1; dc = -2'sd1; end
            4'd1:    begin dr = -2'sd1; dc = 2'sd0;  end
            4'd2:    begin dr = -2'sd1; dc = 2'sd1;  end
            4'd3:    begin dr = 2'sd0;  dc = -2'sd1; end
            4'd4:    begin dr = 2'sd0;  dc = 2'sd0;  end
            4'd5:    begin dr = 2'sd0;  dc = 2'sd1;  end
            4'd6:    begin dr = 2'sd1;  dc = -2'sd1; end
            4'd7:    begin dr = 2'sd1;  dc = 2'sd0;  end
            4'd8:    begin dr = 2'sd1;  dc = 2'sd1;  end
            default: begin dr = 2'sd0;  dc = 2'sd0;  end
        endcase
        wx = (dr == 2'sd0) ? 3'(dc) <<< 1 : 3'(dc);
        wy = (dc == 2'sd0) ? 3'(dr) <<< 1 : 3'(dr);
        case (dr)
            -2'sd1:  offs = -$signed({2'b00, cmd_reg.width});
            2'sd1:   offs = $signed({2'b00, cmd_reg.width});
            default: offs = '0;
        endcase
        kk = $signed({2'b00, cmd_reg.back}) - offs - 13'(dc);
        skip = (dr < 0 && cmd_reg.r_first) || (dr > 0 && cmd_reg.r_last) ||
               (dc < 0 && cmd_reg.c_first) || (dc > 0 && cmd_reg.c_last) ||
               (kk < 0) || (tap_reg == LAST_TAP);
        ram_raddr = cmd_reg.head - kk[RING_AW-1:0];
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            probe[c] = m_reg[c] | (8'd1 << bit_reg);
            prod[c]  = probe[c] * (probe[c] - 8'd1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_TAP;
                end
            end
            ST_TAP:  state_next = (tap_reg == LAST_TAP) ? ST_SQ : ST_TAP;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: state_next = (bit_reg == 3'd0) ? ST_OUT : ST_ROOT;
            ST_OUT:  state_next = edges.ready ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    assign edges.valid      = (state_reg == ST_OUT);
    assign edges.red_edge   = m_reg[0];
    assign edges.green_edge = m_reg[1];
    assign edges.blue_edge  = m_reg[2];
    assign edges.frame_end  = cmd_reg.r_last && cmd_reg.c_last;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg <= cmd_in;
                tv_reg  <= 1'b0;
                for (int c = 0; c < 3; c++)
                begin
                    gx_reg[c] <= '0;
                    gy_reg[c] <= '0;
                end
            end
            ST_TAP:
            begin
                tv_reg <= !skip;
                wx_reg <= wx;
                wy_reg <= wy;
                if (tv_reg)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        gx_reg[c] <= gx_reg[c] + term(wx_reg, ram_rdata[23-8*c -: 8]);
                        gy_reg[c] <= gy_reg[c] + term(wy_reg, ram_rdata[23-8*c -: 8]);
                    end
                end
            end
            ST_SQ:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sqx_reg[c] <= 20'(gx_reg[c] * gx_reg[c]);
                    sqy_reg[c] <= 20'(gy_reg[c] * gy_reg[c]);
                end
            end
            ST_SUM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_reg[c] <= {1'b0, sqx_reg[c]} + {1'b0, sqy_reg[c]};
                    m_reg[c]   <= '0;
                end
            end
            ST_ROOT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if ({5'b00000, prod[c]} < sum_reg[c])
                    begin
                        m_reg[c] <= probe[c];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_TAP)
            begin
                tap_reg <= tap_reg + 4'd1;
            end
            else
            begin
                tap_reg <= '0;
            end
            if (state_reg == ST_ROOT)
            begin
                bit_reg <= bit_reg - 3'd1;
            end
            else
            begin
                bit_reg <= 3'd7;
            end
        end
    end

endmodule

// File: hw/rtl/sobel_edge_rgb.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, with a
// zero border. Input items are taken whenever the command queue is not full.
// For each result the gradient engine pops the command, fetches the nine
// neighbors through the single read port of the pixel ring memory, squares
// and sums the gradients, takes the bit-serial rounded square root and hands
// over the result once the sink is ready; up to four owed results queue
// between the input side and the engine. A result leaves line_width+1 items
// after its pixel; send drain items to flush the last row.
module sobel_edge_rgb
    import sobel_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pix_if.sink                  pixels,
    edge_if.source               edges,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HEIGHT_W-1:0]  cfg_data
);

    logic [WIDTH_W-1:0]  line_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic                ram_we;
    logic [RING_AW-1:0]  ram_waddr, ram_raddr;
    logic [PIX_W-1:0]    ram_wdata, ram_rdata;
    logic                cmd_push, cmd_full, cmd_avail, cmd_pop;
    cmd_t                cmd_push_data, cmd_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= WIDTH_W'(64);
            frame_height_reg <= HEIGHT_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sobel_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_push_data),
        .cmd_full     (cmd_full)
    );

    sobel_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sobel_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .full      (cmd_full),
        .avail     (cmd_avail),
        .pop_data  (cmd_pop_data),
        .pop       (cmd_pop)
    );

    sobel_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd_in    (cmd_pop_data),
        .cmd_pop   (cmd_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .edges     (edges)
    );

endmodule

// File: tb/sv/tb_if.sv
`timescale 1ns / 1ps
// Interfaces pix_if and edge_if come from the RTL; this file holds the
// transaction type used by the testbench checker.
package tb_sobel_types;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_txn_t;
endpackage

// File: tb/sv/tb_checker.sv
`timescale 1ns / 1ps
module sobel_checker
    import sobel_pkg::*;
    import tb_sobel_types::*;
(
    input  logic                clk,
    input  logic                rst_n,
    pix_if.sink                 pix_mon,
    edge_if.sink                edge_mon,
    input  logic                cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HEIGHT_W-1:0] cfg_data,
    output int                  fail_count,
    output int                  owed_count
);
    localparam int RING_N = 2 * MAX_WIDTH + 4;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] history [RING_N];
    int          head_pos;
    int          col_pos;
    int          row_pos;
    int          owed_pixels;
    edge_txn_t   expected_edges [$];

    assign owed_count = expected_edges.size();

    function automatic int active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        return height_reg == 0 ? 1 : int'(height_reg);
    endfunction

    function automatic logic [7:0] rounded_root(int gx, int gy);
        int s;
        int m;
        s = gx * gx + gy * gy;
        if (s > 64770) return 8'd255;
        m = 254;
        while (m > 0 && m * (m - 1) >= s) m--;
        return m[7:0];
    endfunction

    task automatic queue_gradient(input int back);
        int w;
        int h;
        int k;
        int wx;
        int wy;
        int v;
        int gx [3];
        int gy [3];
        logic [23:0] px;
        edge_txn_t t;
        w = active_width();
        h = active_height();
        gx = '{0, 0, 0};
        gy = '{0, 0, 0};
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                k = back - (dr * w + dc);
                if ((dr < 0 && row_pos == 0) || (dr > 0 && row_pos >= h - 1) ||
                    (dc < 0 && col_pos == 0) || (dc > 0 && col_pos >= w - 1) || k < 0)
                    continue;
                px = history[(head_pos + RING_N - (k % RING_N)) % RING_N];
                wx = dc * (dr == 0 ? 2 : 1);
                wy = dr * (dc == 0 ? 2 : 1);
                for (int ch = 0; ch < 3; ch++)
                begin
                    v = int'(px[16 - 8 * ch +: 8]);
                    gx[ch] += wx * v;
                    gy[ch] += wy * v;
                end
            end
        end
        t.red   = rounded_root(gx[0], gy[0]);
        t.green = rounded_root(gx[1], gy[1]);
        t.blue  = rounded_root(gx[2], gy[2]);
        t.last  = (row_pos >= h - 1 && col_pos >= w - 1);
        expected_edges.push_back(t);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edge_txn_t want;
        int w;
        if (!rst_n)
        begin
            width_reg   = 11'd64;
            height_reg  = 16'd64;
            foreach (history[i]) history[i] = '0;
            head_pos    = 0;
            col_pos     = 0;
            row_pos     = 0;
            owed_pixels = 0;
            fail_count  = 0;
            expected_edges.delete();
        end
        else
        begin
            if (edge_mon.valid && edge_mon.ready)
            begin
                if (expected_edges.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = expected_edges.pop_front();
                    if (edge_mon.red_edge !== want.red)
                        report_mismatch("red_edge", edge_mon.red_edge, want.red);
                    if (edge_mon.green_edge !== want.green)
                        report_mismatch("green_edge", edge_mon.green_edge, want.green);
                    if (edge_mon.blue_edge !== want.blue)
                        report_mismatch("blue_edge", edge_mon.blue_edge, want.blue);
                    if (edge_mon.frame_end !== want.last)
                        report_mismatch("frame_end", edge_mon.frame_end, want.last);
                end
            end
            if (pix_mon.valid && pix_mon.ready)
            begin
                w = active_width();
                if (pix_mon.op == OP_PIXEL)
                begin
                    head_pos = (head_pos + 1) % RING_N;
                    history[head_pos] = {pix_mon.red_in, pix_mon.green_in, pix_mon.blue_in};
                    if (owed_pixels >= w + 1)
                    begin
                        owed_pixels = w + 1;
                        queue_gradient(w + 1);
                    end
                    else
                        owed_pixels++;
                end
                else if (owed_pixels > 0)
                begin
                    queue_gradient(owed_pixels - 1);
                    owed_pixels--;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_LINE_WIDTH) width_reg = cfg_data[10:0];
                else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
            end
        end
    end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sobel_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
    logic [HEIGHT_W-1:0]  cfg_data = '0;
    int                   fail_count;
    int                   owed_count;
    int                   cycle_count = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    bit                   hold_off = 1'b0;
    bit                   stall_on = 1'b0;

    pix_if  pixels ();
    edge_if edges ();

    sobel_edge_rgb DUT (
        .clk(clk), .rst_n(rst_n), .pixels(pixels.sink), .edges(edges.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sobel_checker edge_check (
        .clk(clk), .rst_n(rst_n), .pix_mon(pixels.sink), .edge_mon(edges.sink),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .owed_count(owed_count)
    );

    always #5 clk = ~clk;

    initial
    begin
        pixels.valid = 1'b0;
        pixels.op = OP_PIXEL;
        pixels.red_in = '0;
        pixels.green_in = '0;
        pixels.blue_in = '0;
        edges.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            edges.ready <= 1'b0;
        else if (stall_on)
            edges.ready <= ($urandom_range(0, 3) == 0);
        else
            edges.ready <= ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
    end

    task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        if (burst_left == 0)
        begin
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
        end
        while (gap_left > 0)
        begin
            pixels.valid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        pixels.valid <= 1'b1;
        pixels.op <= op;
        pixels.red_in <= r;
        pixels.green_in <= g;
        pixels.blue_in <= b;
        burst_left--;
        do @(posedge clk); while (!pixels.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        pixels.valid <= 1'b0;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        pixels.valid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic run_frame(input int w, input int h, input int mode);
        int v;
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        for (int i = 0; i < w * h; i++)
        begin
            case (mode)
                0: send_item(OP_PIXEL, 8'd255, 8'd0, 8'd255);
                1: send_item(OP_PIXEL, (i % 2) ? 8'd255 : 8'd0, 8'd0,
                             (i % w < w / 2) ? 8'd255 : 8'd0);
                default:
                begin
                    v = $urandom_range(0, 19);
                    if (v == 0)
                        send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
                    else
                        send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
        end
        for (int i = 0; i <= w + 1; i++)
            send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();
    endtask

    task automatic run_partial(input int w, input int h, input int n);
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        for (int i = 0; i < n; i++)
            send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i <= n; i++)
            send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item(OP_DRAIN, 8'd0, 8'd0, 8'd0);
        run_partial(1030, 2, 40);
        run_frame(3, 3, 0);
        run_frame(4, 4, 1);
        run_frame(1, 1, 2);
        run_frame(1, 5, 2);
        run_frame(0, 0, 2);
        run_frame(6, 2, 2);
        fork
            run_frame(10, 12, 2);
            begin
                @(posedge clk);
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
        join
        for (int f = 0; f < 18; f++)
            run_frame($urandom_range(1, 9), $urandom_range(1, 7), 2);
        run_partial(5, 65535, 40);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/sobel_pkg.sv
hw/rtl/sobel_if.sv
hw/rtl/sobel_ram.sv
hw/rtl/sobel_front.sv
hw/rtl/sobel_cmdq.sv
hw/rtl/sobel_back.sv
hw/rtl/sobel_edge_rgb.sv
tb/sv/tb_if.sv
tb/sv/tb_checker.sv
tb/sv/tb_top.sv
